// File: rtl/ftcm_pkg.sv
package ftcm_pkg;

    localparam int MAX_DIMENSION  = 4096;
    localparam int MAX_ITERATIONS = 16;

    localparam int PIX_W     = 12;
    localparam int DIM_W     = 13;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W     = 23;
    localparam int FIX_W     = 32;

    // Divider geometry: magnitude of (p - D/2) times 2^18, quotient bits.
    localparam int MAG_W      = 12;
    localparam int QUO_W      = 30;
    localparam int DIV_STEPS  = 5;
    localparam int DIV_STAGES = QUO_W / DIV_STEPS;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 13'd1024;

    typedef logic signed [FIX_W-1:0] t_fix;

    typedef struct packed {
        logic done;
        t_fix cx;
        t_fix cy;
        t_fix zx;
        t_fix zy;
    } t_zst;

endpackage

// File: rtl/ftcm_pix_if.sv
interface ftcm_pix_if;
    logic                          valid;
    logic                          ready;
    logic [ftcm_pkg::PIX_W-1:0]    pixel_x;
    logic [ftcm_pkg::PIX_W-1:0]    pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// File: rtl/ftcm_src_if.sv
interface ftcm_src_if;
    logic                                valid;
    logic                                ready;
    logic signed [ftcm_pkg::OUT_W-1:0]   source_x_q8;
    logic signed [ftcm_pkg::OUT_W-1:0]   source_y_q8;

    modport source (output valid, output source_x_q8, output source_y_q8, input ready);
    modport sink   (input valid, input source_x_q8, input source_y_q8, output ready);
endinterface

// File: rtl/ftcm_div.sv
module ftcm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [ftcm_pkg::PIX_W-1:0]  i_px,
    input  logic [ftcm_pkg::PIX_W-1:0]  i_py,
    input  logic [ftcm_pkg::DIM_W-1:0]  i_w,
    input  logic [ftcm_pkg::DIM_W-1:0]  i_h,
    output logic                        o_vld,
    output ftcm_pkg::t_fix              o_cx,
    output ftcm_pkg::t_fix              o_cy
);
    import ftcm_pkg::*;

    localparam int NV = DIV_STAGES + 2;

    logic [DIM_W-1:0] dim [0:1];
    logic [PIX_W-1:0] pix [0:1];

    logic [QUO_W-1:0] r_num [0:DIV_STAGES][0:1];
    logic [DIM_W-1:0] r_rem [0:DIV_STAGES][0:1];
    logic [QUO_W-1:0] r_quo [0:DIV_STAGES][0:1];
    logic             r_neg [0:DIV_STAGES][0:1];
    logic             r_vld [0:NV-1];
    t_fix             r_c   [0:1];

    assign dim[0] = i_w;
    assign dim[1] = i_h;
    assign pix[0] = i_px;
    assign pix[1] = i_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NV; s++) r_vld[s] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int s = 1; s < NV; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    // Front stage: signed offset from the image center, split into sign and magnitude.
    for (genvar a = 0; a < 2; a++) begin : g_front
        logic signed [PIX_W+1:0] n_d;
        logic [PIX_W+1:0]        n_mag;
        always_comb begin
            n_d   = $signed({2'b00, pix[a]}) - $signed({2'b00, dim[a][DIM_W-1:1]});
            n_mag = n_d[PIX_W+1] ? 14'(-n_d) : 14'(n_d);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[0][a] <= {n_mag[MAG_W-1:0], {(QUO_W-MAG_W){1'b0}}};
                r_rem[0][a] <= '0;
                r_quo[0][a] <= '0;
                r_neg[0][a] <= n_d[PIX_W+1];
            end
        end
    end

    // Restoring division, a few quotient bits per stage.
    for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_stage
        for (genvar a = 0; a < 2; a++) begin : g_axis
            logic [QUO_W-1:0] n_num;
            logic [DIM_W-1:0] n_rem;
            logic [QUO_W-1:0] n_quo;
            always_comb begin
                logic [DIM_W:0] t;
                n_num = r_num[s-1][a];
                n_rem = r_rem[s-1][a];
                n_quo = r_quo[s-1][a];
                for (int k = 0; k < DIV_STEPS; k++) begin
                    t     = {n_rem, n_num[QUO_W-1]};
                    n_num = {n_num[QUO_W-2:0], 1'b0};
                    if (t >= {1'b0, dim[a]}) begin
                        t     = t - {1'b0, dim[a]};
                        n_quo = {n_quo[QUO_W-2:0], 1'b1};
                    end else begin
                        n_quo = {n_quo[QUO_W-2:0], 1'b0};
                    end
                    n_rem = t[DIM_W-1:0];
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_num[s][a] <= n_num;
                    r_rem[s][a] <= n_rem;
                    r_quo[s][a] <= n_quo;
                    r_neg[s][a] <= r_neg[s-1][a];
                end
            end
        end
    end

    for (genvar a = 0; a < 2; a++) begin : g_sign
        t_fix n_c;
        always_comb begin
            n_c = $signed({{(FIX_W-QUO_W){1'b0}}, r_quo[DIV_STAGES][a]});
            if (r_neg[DIV_STAGES][a]) n_c = -n_c;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) r_c[a] <= n_c;
        end
    end

    assign o_vld = r_vld[NV-1];
    assign o_cx  = r_c[0];
    assign o_cy  = r_c[1];

endmodule

// File: rtl/ftcm_iter.sv
module ftcm_iter #(
    parameter int P_K       = 0,
    parameter int P_DEPTH_W = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [P_DEPTH_W-1:0] i_depth,
    input  logic                 i_vld,
    input  ftcm_pkg::t_zst       i_z,
    output logic                 o_vld,
    output ftcm_pkg::t_zst       o_z
);
    import ftcm_pkg::*;

    localparam logic [P_DEPTH_W-1:0] K = P_K[P_DEPTH_W-1:0];
    localparam logic signed [48:0]   ESCAPE = 49'sd262144;

    logic                r_vld_a;
    logic                r_act;
    t_zst                r_z_a;
    logic signed [63:0]  r_pxx;
    logic signed [63:0]  r_pyy;
    logic signed [63:0]  r_pxy;
    logic                r_vld_b;
    t_zst                r_z_b;

    logic signed [47:0]  zx2;
    logic signed [47:0]  zy2;
    logic signed [48:0]  mag2;
    t_zst                n_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
        end
    end

    // First half: the three products of this iteration.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z_a <= i_z;
            r_act <= !i_z.done && (i_depth > K);
            r_pxx <= i_z.zx * i_z.zx;
            r_pyy <= i_z.zy * i_z.zy;
            r_pxy <= i_z.zx * i_z.zy;
        end
    end

    // Second half: escape test, then the update. When the point has not escaped,
    // both squares are small, so the new z fits the fixed-point word exactly.
    always_comb begin
        zx2  = r_pxx[63:16];
        zy2  = r_pyy[63:16];
        mag2 = {zx2[47], zx2} + {zy2[47], zy2};
        n_z  = r_z_a;
        if (r_act) begin
            if (mag2 > ESCAPE) begin
                n_z.done = 1'b1;
            end else begin
                n_z.zx = zx2[FIX_W-1:0] - zy2[FIX_W-1:0] + r_z_a.cx;
                n_z.zy = r_pxy[FIX_W+14:15] + r_z_a.cy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_z_b <= n_z;
    end

    assign o_vld = r_vld_b;
    assign o_z   = r_z_b;

endmodule

// File: rtl/ftcm_out.sv
module ftcm_out (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_vld,
    input  ftcm_pkg::t_fix                   i_zx,
    input  ftcm_pkg::t_fix                   i_zy,
    input  logic [ftcm_pkg::DIM_W-1:0]       i_w,
    input  logic [ftcm_pkg::DIM_W-1:0]       i_h,
    output logic                             o_vld,
    output logic signed [ftcm_pkg::OUT_W-1:0] o_sx,
    output logic signed [ftcm_pkg::OUT_W-1:0] o_sy
);
    import ftcm_pkg::*;

    localparam int PW = FIX_W + DIM_W + 1;

    logic                  r_vld_a;
    logic                  r_vld_b;
    logic signed [PW-1:0]  r_prod [0:1];
    logic signed [OUT_W-1:0] r_s  [0:1];
    logic [DIM_W-1:0]      dim  [0:1];
    t_fix                  z    [0:1];

    assign dim[0] = i_w;
    assign dim[1] = i_h;
    assign z[0]   = i_zx;
    assign z[1]   = i_zy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
        end
    end

    for (genvar a = 0; a < 2; a++) begin : g_axis
        logic signed [PW-1:0] n_adj;
        logic signed [PW-1:0] n_sum;
        always_comb begin
            // Division by 1024 rounds toward zero.
            n_adj = r_prod[a];
            if (r_prod[a][PW-1]) n_adj = r_prod[a] + PW'(1023);
            n_sum = (n_adj >>> 10) + $signed({{(PW-DIM_W-7){1'b0}}, dim[a], 7'b0});
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_prod[a] <= z[a] * $signed({1'b0, dim[a]});
                r_s[a]    <= n_sum[OUT_W-1:0];
            end
        end
    end

    assign o_vld = r_vld_b;
    assign o_sx  = r_s[0];
    assign o_sy  = r_s[1];

endmodule

// File: rtl/fractal_trace_coordinate_map.sv
// Maps each destination pixel to a source coordinate through a Mandelbrot warp. The pixel
// is scaled to c in 16.16 fixed point spanning about -2..2, z = z^2 + c runs for up to
// iteration_depth steps (stopping once |z|^2 exceeds 4), and the final z is scaled back
// to a source position with 8 fraction bits. The block is a fixed pipeline: one pixel
// is taken every cycle unless the output stalls, and each passes through eight stages
// of center offset and restoring division, two stages per unrolled iteration, and two
// for the final scaling. A stall at the output freezes the whole pipeline, so ready
// follows the output side combinationally. Registers: 0 image width, 1 image height
// (both saturate to 1..4096), 2 iteration depth (saturates to 1..P_MAX_ITER). Write
// them only while the pipeline is empty.
module fractal_trace_coordinate_map #(
    parameter int P_MAX_ITER = ftcm_pkg::MAX_ITERATIONS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ftcm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ftcm_pkg::CFG_W-1:0]     i_cfg_data,
    ftcm_pix_if.sink                      i_pix,
    ftcm_src_if.source                    o_src
);
    import ftcm_pkg::*;

    localparam int DEPTH_W   = $clog2(P_MAX_ITER + 1);
    localparam int DEPTH_RST = (P_MAX_ITER < 8) ? P_MAX_ITER : 8;

    logic [DIM_W-1:0]   r_w;
    logic [DIM_W-1:0]   r_h;
    logic [DEPTH_W-1:0] r_depth;
    logic [DIM_W-1:0]   n_dim;
    logic [DEPTH_W-1:0] n_depth;
    logic               en;

    always_comb begin
        n_dim = i_cfg_data;
        if (i_cfg_data == '0) n_dim = DIM_W'(1);
        else if (i_cfg_data > CFG_W'(MAX_DIMENSION)) n_dim = DIM_W'(MAX_DIMENSION);
        if (i_cfg_data == '0) n_depth = DEPTH_W'(1);
        else if (i_cfg_data > CFG_W'(P_MAX_ITER)) n_depth = DEPTH_W'(P_MAX_ITER);
        else n_depth = i_cfg_data[DEPTH_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w     <= DIM_RESET;
            r_h     <= DIM_RESET;
            r_depth <= DEPTH_W'(DEPTH_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:  r_w     <= n_dim;
                CFG_HEIGHT: r_h     <= n_dim;
                CFG_DEPTH:  r_depth <= n_depth;
                default: ;
            endcase
        end
    end

    assign en          = !o_src.valid || o_src.ready;
    assign i_pix.ready = en;

    logic  d_vld;
    t_fix  d_cx;
    t_fix  d_cy;

    ftcm_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (i_pix.valid),
        .i_px   (i_pix.pixel_x),
        .i_py   (i_pix.pixel_y),
        .i_w    (r_w),
        .i_h    (r_h),
        .o_vld  (d_vld),
        .o_cx   (d_cx),
        .o_cy   (d_cy)
    );

    logic vld_chain [0:P_MAX_ITER];
    t_zst z_chain   [0:P_MAX_ITER];

    assign vld_chain[0] = d_vld;
    assign z_chain[0]   = '{done: 1'b0, cx: d_cx, cy: d_cy, zx: d_cx, zy: d_cy};

    for (genvar k = 0; k < P_MAX_ITER; k++) begin : g_iter
        ftcm_iter #(
            .P_K      (k),
            .P_DEPTH_W(DEPTH_W)
        ) u_iter (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_depth(r_depth),
            .i_vld  (vld_chain[k]),
            .i_z    (z_chain[k]),
            .o_vld  (vld_chain[k+1]),
            .o_z    (z_chain[k+1])
        );
    end

    ftcm_out u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (vld_chain[P_MAX_ITER]),
        .i_zx   (z_chain[P_MAX_ITER].zx),
        .i_zy   (z_chain[P_MAX_ITER].zy),
        .i_w    (r_w),
        .i_h    (r_h),
        .o_vld  (o_src.valid),
        .o_sx   (o_src.source_x_q8),
        .o_sy   (o_src.source_y_q8)
    );

endmodule

// File: rtl/ftcm_chk.sv
module ftcm_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic signed [ftcm_pkg::OUT_W-1:0] i_sx,
    input logic signed [ftcm_pkg::OUT_W-1:0] i_sy
);
    // The pipeline advances exactly when the output register is free or being taken.
    a_ready_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not track the output side");

    // A stalled result stays put until it is transferred.
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_sx) && $stable(i_sy))
        else $error("stalled result changed");

    // Nothing comes out right after reset.
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result presented straight after reset");

endmodule

bind fractal_trace_coordinate_map ftcm_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (i_pix.ready),
    .i_out_valid(o_src.valid),
    .i_out_ready(o_src.ready),
    .i_sx       (o_src.source_x_q8),
    .i_sy       (o_src.source_y_q8)
);

// File: bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ftcm_pkg::*;

    typedef struct {
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
    } pixel_t;

    typedef struct {
        logic signed [OUT_W-1:0] sx;
        logic signed [OUT_W-1:0] sy;
    } source_t;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 60;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    ftcm_pix_if pix ();
    ftcm_src_if src ();

    fractal_trace_coordinate_map uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix.sink),
        .o_src      (src.source)
    );

    // Shadow copy of the register file.
    int unsigned img_w;
    int unsigned img_h;
    int unsigned depth;

    pixel_t  pending_pixels[$];
    source_t expected_sources[$];

    int  error_count;
    int  pixels_sent;
    int  sources_checked;
    int  phase_count;
    int  idle_cycles;
    bit  calm;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic int unsigned clamp_dimension(int unsigned v);
        if (v < 1) return 1;
        if (v > MAX_DIMENSION) return MAX_DIMENSION;
        return v;
    endfunction

    function automatic longint plane_coord(int unsigned p, int unsigned dim);
        longint offset;
        offset = longint'(p) - longint'(dim / 2);
        return (offset * 262144) / longint'(dim);
    endfunction

    function automatic logic signed [OUT_W-1:0] source_coord(longint z, int unsigned dim);
        longint s;
        s = longint'(dim) * 128 + (z * longint'(dim)) / 1024;
        return s[OUT_W-1:0];
    endfunction

    function automatic source_t warp_pixel(pixel_t p);
        longint cx, cy, zx, zy, zx2, zy2, nx, ny;
        source_t r;
        cx = plane_coord(p.px, img_w);
        cy = plane_coord(p.py, img_h);
        zx = cx;
        zy = cy;
        for (int k = 0; k < depth; k++) begin
            zx2 = (zx * zx) >>> 16;
            zy2 = (zy * zy) >>> 16;
            if (zx2 + zy2 > (longint'(4) << 16)) break;
            nx = zx2 - zy2 + cx;
            ny = ((zx * zy) >>> 15) + cy;
            zx = nx;
            zy = ny;
        end
        r.sx = source_coord(zx, img_w);
        r.sy = source_coord(zy, img_h);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic signed [OUT_W-1:0] got,
                                   logic signed [OUT_W-1:0] want);
        $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
                 sources_checked);
        error_count++;
    endtask

    // Pixel driver.
    int unsigned send_gap;
    always @(posedge i_clk) begin
        pixel_t item;
        if (!i_rst_n) begin
            pix.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (pix.valid && pix.ready) begin
                item.px = pix.pixel_x;
                item.py = pix.pixel_y;
                expected_sources.push_back(warp_pixel(item));
                pixels_sent++;
            end
            if (!pix.valid || pix.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    pix.valid <= 1'b0;
                end else if (pending_pixels.size() > 0) begin
                    item = pending_pixels.pop_front();
                    pix.valid   <= 1'b1;
                    pix.pixel_x <= item.px;
                    pix.pixel_y <= item.py;
                    if (!calm && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 16);
                end else begin
                    pix.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random output stalls.
    int unsigned stall_left;
    always @(posedge i_clk) begin
        source_t want;
        if (!i_rst_n) begin
            src.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (src.valid && src.ready) begin
                if (expected_sources.size() == 0) begin
                    $display("UNEXPECTED result: %0d %0d", src.source_x_q8, src.source_y_q8);
                    error_count++;
                end else begin
                    want = expected_sources.pop_front();
                    if (src.source_x_q8 !== want.sx)
                        report_mismatch("source_x_q8", src.source_x_q8, want.sx);
                    if (src.source_y_q8 !== want.sy)
                        report_mismatch("source_y_q8", src.source_y_q8, want.sy);
                end
                sources_checked++;
            end
            if (stall_left > 0) begin
                stall_left--;
                src.ready <= 1'b0;
            end else begin
                src.ready <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 16);
            end
        end
    end

    // A run with no transfer for too long has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix.valid && pix.ready) || (src.valid && src.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout after %0d cycles without a transfer", idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[CFG_W-1:0];
        value = value & ((1 << CFG_W) - 1);
        case (idx)
            CFG_WIDTH:  img_w = clamp_dimension(value);
            CFG_HEIGHT: img_h = clamp_dimension(value);
            CFG_DEPTH:  depth = (value < 1) ? 1 : (value > MAX_ITERATIONS) ?
                                MAX_ITERATIONS : value;
            default: ;
        endcase
    endtask

    task automatic configure(int unsigned w, int unsigned h, int unsigned d);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_DEPTH, d);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_pixels.size() != 0 || pix.valid || expected_sources.size() != 0);
        phase_count++;
    endtask

    task automatic queue_pixel(int unsigned x, int unsigned y);
        pixel_t p;
        p.px = x[PIX_W-1:0];
        p.py = y[PIX_W-1:0];
        pending_pixels.push_back(p);
    endtask

    task automatic queue_random_pixels(int n);
        for (int i = 0; i < n; i++) begin
            // Mostly pixels inside the image, some anywhere in the 12-bit range.
            if ($urandom_range(0, 7) == 0)
                queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
            else
                queue_pixel($urandom_range(0, img_w - 1), $urandom_range(0, img_h - 1));
        end
    endtask

    initial begin
        int unsigned w, h, d;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        pix.valid   = 1'b0;
        pix.pixel_x = '0;
        pix.pixel_y = '0;
        src.ready   = 1'b0;
        img_w = 1024;
        img_h = 1024;
        depth = 8;
        calm  = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: corners, center, and pixels past the image edge.
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        queue_pixel(4095, 0);
        queue_pixel(0, 4095);
        queue_pixel(512, 512);
        queue_pixel(1023, 1023);
        queue_pixel(1024, 1024);
        queue_pixel(256, 768);
        queue_pixel(600, 512);
        queue_pixel(2048, 100);
        wait_drained();

        // One-pixel image at minimum depth, then the largest image at full depth.
        configure(1, 1, 1);
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        queue_pixel(1, 2);
        wait_drained();
        configure(4096, 4096, 16);
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        queue_pixel(2048, 2048);
        queue_pixel(1500, 2048);
        wait_drained();

        // Zero and oversized writes saturate; an unknown index is ignored.
        configure(0, 8191, 0);
        write_reg(2'd3, $urandom_range(0, 8191));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        queue_pixel(0, 4095);
        queue_pixel(4095, 2048);
        queue_pixel(0, 0);
        wait_drained();
        configure(640, 480, 8191);
        queue_pixel(320, 240);
        queue_pixel(639, 479);
        queue_pixel(100, 300);
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            case ($urandom_range(0, 3))
                0: w = $urandom_range(1, 16);
                1: w = $urandom_range(1, 8191);
                default: w = $urandom_range(1, 4096);
            endcase
            h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 4096);
            d = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 16);
            configure(w, h, d);
            if (ph == 7) calm = 1'b1;
            queue_random_pixels(90);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d pixels and %0d results over %0d configuration phases,",
                 pixels_sent, sources_checked, phase_count);
        $display("including degenerate, saturated and out-of-image cases.");
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/ftcm_pkg.sv
rtl/ftcm_pix_if.sv
rtl/ftcm_src_if.sv
rtl/ftcm_div.sv
rtl/ftcm_iter.sv
rtl/ftcm_out.sv
rtl/fractal_trace_coordinate_map.sv
rtl/ftcm_chk.sv
bench/tb.sv
